// File: src/tnsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread name slot cache package
// Field widths, result status codes and shared constants of the name cache.
// ----------------------------------------------------------------------------
package tnsc_pkg;

	// Fixed field widths of the transaction payloads.
	localparam int unsigned TID_W       = 32;
	localparam int unsigned NAME_LOW_W  = 64;
	localparam int unsigned NAME_HIGH_W = 56;
	localparam int unsigned SLOT_OUT_W  = 7;

	// The input carries name bytes 0 to 14; byte 15 is padded with zero.
	localparam int unsigned RAW_NAME_BYTES = 16;

	// Result status codes.
	typedef enum logic [0:0] {
		STATUS_OK        = 1'b0,
		STATUS_NOT_READY = 1'b1
	} status_t;

endpackage : tnsc_pkg
`default_nettype wire

// File: src/thread_name_slot_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread name slot cache
// Records thread names in a round-robin set of slots, found through a map
// indexed by the low bits of the thread id.
// ----------------------------------------------------------------------------
// After reset the block sweeps its map and slot id memories to their empty
// state, one entry per cycle; input transactions are held off during that
// time, while writes to the store_ready register are taken as usual. An
// accepted input transaction passes through a lookup state and a check
// state, where its result is registered; the block then returns to idle to
// accept the next input, passing first through a clear state when the slot
// it lands in evicts a thread whose map entry differs from its own, since
// that entry is cleared through the single write port of the map. The
// sequence is set by the dependent registered reads of the map memory and
// then the slot id memory. A finished result waits in an output register,
// and the block goes on to accept the next input transaction while it does;
// that transaction then waits in its last step until the output register
// is free.
// ----------------------------------------------------------------------------
module thread_name_slot_cache
	import tnsc_pkg::*;
#(
	parameter int unsigned MAP_ENTRIES = 32768,
	parameter int unsigned SLOT_COUNT  = 128,
	parameter int unsigned NAME_BYTES  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration register write.
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_wdata,
	// Input transactions.
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [TID_W-1:0]       tid,
	input  wire logic [NAME_LOW_W-1:0]  name_low,
	input  wire logic [NAME_HIGH_W-1:0] name_high,
	// Result transactions.
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        status,
	output logic [SLOT_OUT_W-1:0]       slot,
	output logic                        slot_was_new,
	output logic                        evicted_valid,
	output logic [TID_W-1:0]            evicted_tid
);

	localparam int unsigned MW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned NW = NAME_BYTES * 8;
	localparam int unsigned INIT_DEPTH =
		(MAP_ENTRIES > SLOT_COUNT) ? MAP_ENTRIES : SLOT_COUNT;
	localparam int unsigned IW = $clog2(INIT_DEPTH) + 1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOKUP,
		ST_CHECK,
		ST_CLEAR
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   init_q;
	logic            store_ready_q;
	logic [SW-1:0]   next_slot_q;
	logic            out_valid_q;
	status_t         out_status_q;
	logic [SW-1:0]   out_slot_q;
	logic            out_new_q;
	logic            out_ev_q;
	logic [TID_W-1:0] out_ev_tid_q;
	logic [MW-1:0]   oidx_q;

	logic [TID_W-1:0] tid_s1;
	logic [MW-1:0]    idx_s1;
	logic [NW-1:0]    name_s1;
	logic [SW-1:0]    slot_s2;
	logic             was_new_s2;

	logic            accept;
	logic [MW-1:0]   in_idx;
	logic [NW-1:0]   name_word;
	logic            map_hit;
	logic [SW-1:0]   slot_sel;
	logic [SW-1:0]   next_slot_inc;
	logic            evict;
	logic [MW-1:0]   old_idx;
	logic            go;

	logic            map_wr_en;
	logic [MW-1:0]   map_wr_addr;
	logic [SW:0]     map_wr_data;
	logic [SW:0]     map_rd_data;
	logic            stid_wr_en;
	logic [SW-1:0]   stid_wr_addr;
	logic [TID_W-1:0] stid_wr_data;
	logic [TID_W-1:0] stid_rd_data;
	logic            name_wr_en;

	// Handshake and index decode.
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_idx   = tid[MW-1:0] & MW'(MAP_ENTRIES - 1);

	// Map lookup result: a valid entry holding a legal slot is a hit.
	assign map_hit  = map_rd_data[SW] &&
		((SW+1)'(map_rd_data[SW-1:0]) < (SW+1)'(SLOT_COUNT));
	assign slot_sel = map_hit ? map_rd_data[SW-1:0] : next_slot_q;
	assign next_slot_inc = (next_slot_q == SW'(SLOT_COUNT - 1)) ?
		'0 : next_slot_q + 1'b1;

	// Slot owner check.
	assign evict   = (stid_rd_data != tid_s1);
	assign old_idx = stid_rd_data[MW-1:0] & MW'(MAP_ENTRIES - 1);
	assign go      = (state_q == ST_CHECK) && (!out_valid_q || out_ready);

	// Map write port: reset sweep, entry set, evicted entry clear.
	always_comb begin
		map_wr_en   = 1'b0;
		map_wr_addr = idx_s1;
		map_wr_data = '0;
		unique case (state_q)
			ST_INIT: begin
				map_wr_en   = (init_q < IW'(MAP_ENTRIES));
				map_wr_addr = init_q[MW-1:0];
			end
			ST_CHECK: begin
				map_wr_en   = go && store_ready_q;
				map_wr_data = {1'b1, slot_s2};
			end
			ST_CLEAR: begin
				map_wr_en   = 1'b1;
				map_wr_addr = oidx_q;
			end
			default: begin
				map_wr_en = 1'b0;
			end
		endcase
	end

	// Slot id write port: reset sweep or new owner.
	always_comb begin
		if (state_q == ST_INIT) begin
			stid_wr_en   = (init_q < IW'(SLOT_COUNT));
			stid_wr_addr = init_q[SW-1:0];
			stid_wr_data = '0;
		end else begin
			stid_wr_en   = go && store_ready_q && evict;
			stid_wr_addr = slot_s2;
			stid_wr_data = tid_s1;
		end
	end

	assign name_wr_en = go && store_ready_q;

	// Name formatting at the input.
	tnsc_name_pack #(
		.NAME_BYTES (NAME_BYTES)
	) u_name_pack (
		.name_low  (name_low),
		.name_high (name_high),
		.name_word (name_word)
	);

	// Thread id map: valid bit over slot number.
	tnsc_ram #(
		.WIDTH (SW + 1),
		.DEPTH (MAP_ENTRIES)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (map_rd_data)
	);

	// Owner thread id of each slot.
	tnsc_ram #(
		.WIDTH (TID_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_tid_ram (
		.clk     (clk),
		.wr_en   (stid_wr_en),
		.wr_addr (stid_wr_addr),
		.wr_data (stid_wr_data),
		.rd_en   (state_q == ST_LOOKUP),
		.rd_addr (slot_sel),
		.rd_data (stid_rd_data)
	);

	// Stored names of each slot.
	tnsc_ram #(
		.WIDTH (NW),
		.DEPTH (SLOT_COUNT)
	) u_slot_name_ram (
		.clk     (clk),
		.wr_en   (name_wr_en),
		.wr_addr (slot_s2),
		.wr_data (name_s1),
		.rd_en   (1'b0),
		.rd_addr ('0),
		.rd_data ()
	);

	// Sequencer, configuration register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			init_q        <= '0;
			store_ready_q <= 1'b0;
			next_slot_q   <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= STATUS_OK;
			out_slot_q    <= '0;
			out_new_q     <= 1'b0;
			out_ev_q      <= 1'b0;
			out_ev_tid_q  <= '0;
			oidx_q        <= '0;
		end else begin
			if (cfg_we) begin
				store_ready_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && !go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == IW'(INIT_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (store_ready_q && !map_hit) begin
						next_slot_q <= next_slot_inc;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (go) begin
						out_valid_q <= 1'b1;
						oidx_q      <= old_idx;
						if (store_ready_q) begin
							out_status_q <= STATUS_OK;
							out_slot_q   <= slot_s2;
							out_new_q    <= was_new_s2;
							out_ev_q     <= evict;
							out_ev_tid_q <= evict ? stid_rd_data : '0;
							state_q      <= (evict && old_idx != idx_s1) ?
								ST_CLEAR : ST_IDLE;
						end else begin
							out_status_q <= STATUS_NOT_READY;
							out_slot_q   <= '0;
							out_new_q    <= 1'b0;
							out_ev_q     <= 1'b0;
							out_ev_tid_q <= '0;
							state_q      <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			tid_s1  <= tid;
			idx_s1  <= in_idx;
			name_s1 <= name_word;
		end
		if (state_q == ST_LOOKUP) begin
			slot_s2    <= slot_sel;
			was_new_s2 <= !map_hit;
		end
	end

	// Result ports.
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign slot          = SLOT_OUT_W'(out_slot_q);
	assign slot_was_new  = out_new_q;
	assign evicted_valid = out_ev_q;
	assign evicted_tid   = out_ev_tid_q;

	// The map is never written while the block waits for input.
	a_no_map_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !map_wr_en)
		else $error("map written while idle");

	// A reported eviction always belongs to a successful transaction.
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ev_q) |-> (out_status_q == STATUS_OK))
		else $error("eviction reported on a failed transaction");

	// The round-robin pointer stays within the slot range.
	a_next_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SW+1)'(next_slot_q) < (SW+1)'(SLOT_COUNT))
		else $error("round-robin pointer out of range");

	// Outside the reset sweep, slot owners change only while the store is ready.
	a_stid_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(stid_wr_en && state_q != ST_INIT) |-> store_ready_q)
		else $error("slot owner written while store not ready");

	// The clear pass never removes the entry that was just set.
	a_clear_other_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (oidx_q != idx_s1 && $past(state_q) == ST_CHECK))
		else $error("clear pass hit the current map entry");

endmodule : thread_name_slot_cache
`default_nettype wire

// File: src/tnsc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tnsc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : tnsc_ram
`default_nettype wire

// File: src/tnsc_name_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thread name packer
// Forms the stored name word: bytes after the first zero byte are cleared and
// the last byte of the slot is always zero.
// ----------------------------------------------------------------------------
module tnsc_name_pack
	import tnsc_pkg::*;
#(
	parameter int unsigned NAME_BYTES = 16
) (
	input  wire logic [NAME_LOW_W-1:0]   name_low,
	input  wire logic [NAME_HIGH_W-1:0]  name_high,
	output logic      [NAME_BYTES*8-1:0] name_word
);

	logic [RAW_NAME_BYTES*8-1:0] raw;
	logic [RAW_NAME_BYTES-1:0]   nonzero;

	// Flag every nonzero input byte.
	always_comb begin
		raw = {8'h00, name_high, name_low};
		for (int i = 0; i < RAW_NAME_BYTES; i++) begin
			nonzero[i] = (raw[i*8 +: 8] != 8'h00);
		end
	end

	// A byte is kept only if it and all bytes before it are nonzero.
	always_comb begin
		logic keep;
		keep = 1'b0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			keep = (i < NAME_BYTES - 1);
			for (int j = 0; j < RAW_NAME_BYTES; j++) begin
				if (j <= i) begin
					keep = keep & nonzero[j];
				end
			end
			name_word[i*8 +: 8] = keep ? raw[i*8 +: 8] : 8'h00;
		end
	end

endmodule : tnsc_name_pack
`default_nettype wire

// File: bench/tb_thread_name_slot_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thread name slot cache testbench
// Drives thread id and name transactions into the cache and predicts each
// slot assignment with a local copy of the id map, slot owners and the
// round-robin pointer. A short table covers reset state, field extremes,
// map aliasing and the not-ready case. Random traffic follows, with idle
// gaps on both channels, a long output hold-off and store_ready phases.
// ----------------------------------------------------------------------------
module tb_thread_name_slot_cache;
	import tnsc_pkg::*;

	localparam int unsigned MAP_ENTRIES = 32768;
	localparam int unsigned SLOT_COUNT  = 128;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned POOL_MAX    = 180;
	localparam int unsigned PHASES      = 6;

	// One predicted result transaction.
	typedef struct packed {
		status_t                 status;
		logic [SLOT_OUT_W-1:0]   slot;
		logic                    was_new;
		logic                    evicted;
		logic [TID_W-1:0]        ev_tid;
	} name_result_t;

	typedef enum logic [0:0] {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	// One line of the directed table.
	typedef struct packed {
		row_kind_t               kind;
		logic                    typed;
		logic [TID_W-1:0]        tid;
		logic [NAME_LOW_W-1:0]   lo;
		logic [NAME_HIGH_W-1:0]  hi;
		name_result_t            res;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic                   cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic [TID_W-1:0]       tid;
	logic [NAME_LOW_W-1:0]  name_low;
	logic [NAME_HIGH_W-1:0] name_high;
	logic                   out_valid;
	logic                   out_ready;
	logic                   status;
	logic [SLOT_OUT_W-1:0]  slot;
	logic                   slot_was_new;
	logic                   evicted_valid;
	logic [TID_W-1:0]       evicted_tid;

	thread_name_slot_cache #(
		.MAP_ENTRIES(MAP_ENTRIES),
		.SLOT_COUNT (SLOT_COUNT),
		.NAME_BYTES (16)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.tid          (tid),
		.name_low     (name_low),
		.name_high    (name_high),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot         (slot),
		.slot_was_new (slot_was_new),
		.evicted_valid(evicted_valid),
		.evicted_tid  (evicted_tid)
	);

	// Predictor state: id map, slot owners, round-robin pointer, register.
	bit                    map_used    [MAP_ENTRIES];
	bit [SLOT_OUT_W-1:0]   map_slot_of [MAP_ENTRIES];
	bit [TID_W-1:0]        slot_owner  [SLOT_COUNT];
	bit [SLOT_OUT_W-1:0]   rr_ptr;
	bit                    store_on;

	name_result_t          expected_slots[$];
	stim_row_t             dir_rows[$];
	logic [TID_W-1:0]      tid_pool[$];

	int unsigned mismatches;
	int unsigned names_sent;
	int unsigned results_seen;
	int unsigned new_slots;
	int unsigned evictions;
	int unsigned refused;
	bit          quiet;
	bit          hold_req;

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the slot assignment for one accepted transaction.
	function automatic name_result_t predict_slot(input logic [TID_W-1:0] t);
		name_result_t     r;
		logic [14:0]      idx;
		logic [TID_W-1:0] prev;
		r = '0;
		if (!store_on) begin
			r.status = STATUS_NOT_READY;
			return r;
		end
		r.status = STATUS_OK;
		idx = t[14:0];
		if (map_used[idx]) begin
			r.slot = map_slot_of[idx];
		end else begin
			r.slot = rr_ptr;
			rr_ptr = rr_ptr + 1'b1;
			r.was_new = 1'b1;
		end
		prev = slot_owner[r.slot];
		// The old owner's map entry is cleared before the new one is set.
		if (prev != t) begin
			map_used[prev[14:0]] = 1'b0;
			map_slot_of[prev[14:0]] = '0;
			slot_owner[r.slot] = t;
			r.evicted = 1'b1;
			r.ev_tid = prev;
		end
		map_used[idx] = 1'b1;
		map_slot_of[idx] = r.slot;
		return r;
	endfunction

	function automatic name_result_t mk_res(input status_t st, input int unsigned s,
			input bit nw, input bit ev, input logic [TID_W-1:0] et);
		name_result_t r;
		r.status = st;
		r.slot = s[SLOT_OUT_W-1:0];
		r.was_new = nw;
		r.evicted = ev;
		r.ev_tid = et;
		return r;
	endfunction

	task automatic add_item(input bit typed, input logic [TID_W-1:0] t,
			input logic [NAME_LOW_W-1:0] lo, input logic [NAME_HIGH_W-1:0] hi,
			input name_result_t res);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.typed = typed;
		row.tid = t;
		row.lo = lo;
		row.hi = hi;
		row.res = res;
		dir_rows.push_back(row);
	endtask

	task automatic add_cfg(input bit v);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.lo[0] = v;
		dir_rows.push_back(row);
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Thread ids: reuse from a pool, aliases of pooled ids, small and fresh ids.
	function automatic logic [TID_W-1:0] pick_tid();
		int unsigned      sel;
		logic [TID_W-1:0] t;
		logic [TID_W-1:0] rnd;
		sel = $urandom_range(99);
		rnd = $urandom;
		if (tid_pool.size() == 0 || sel < 25) begin
			t = rnd;
			tid_pool.push_back(t);
			if (tid_pool.size() > POOL_MAX)
				tid_pool.delete($urandom_range(tid_pool.size() - 1));
		end else if (sel < 70) begin
			t = tid_pool[$urandom_range(tid_pool.size() - 1)];
		end else if (sel < 88) begin
			t = tid_pool[$urandom_range(tid_pool.size() - 1)];
			t[31:15] = rnd[16:0];
		end else begin
			t = $urandom_range(40);
		end
		return t;
	endfunction

	task automatic report_mismatch(input string what, input logic [TID_W-1:0] got,
			input logic [TID_W-1:0] want);
		mismatches++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
			got, want);
	endtask

	// Wait until every predicted result has arrived, with the input idle.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_slots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_store_ready(input bit v);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		store_on = v;
	endtask

	// Offer one name transaction after a random gap and predict its result.
	task automatic send_name(input logic [TID_W-1:0] t, input logic [NAME_LOW_W-1:0] lo,
			input logic [NAME_HIGH_W-1:0] hi, input bit typed, input name_result_t want);
		int unsigned  g;
		name_result_t pred;
		g = quiet ? 0 : pick_gap();
		@(negedge clk);
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		tid <= t;
		name_low <= lo;
		name_high <= hi;
		do
			@(posedge clk);
		while (!in_ready);
		pred = predict_slot(t);
		expected_slots.push_back(typed ? want : pred);
		names_sent++;
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int unsigned g;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			g = quiet ? 0 : pick_gap();
			if (g != 0) begin
				out_ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		name_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_slots.size() == 0) begin
				report_mismatch("result with no pending prediction, slot",
					TID_W'(slot), '0);
			end else begin
				want = expected_slots.pop_front();
				results_seen++;
				if (want.was_new)
					new_slots++;
				if (want.evicted)
					evictions++;
				if (want.status == STATUS_NOT_READY)
					refused++;
				if (status != want.status)
					report_mismatch("status", TID_W'(status), TID_W'(want.status));
				if (slot != want.slot)
					report_mismatch("slot", TID_W'(slot), TID_W'(want.slot));
				if (slot_was_new != want.was_new)
					report_mismatch("slot_was_new", TID_W'(slot_was_new),
						TID_W'(want.was_new));
				if (evicted_valid != want.evicted)
					report_mismatch("evicted_valid", TID_W'(evicted_valid),
						TID_W'(want.evicted));
				if (evicted_tid != want.ev_tid)
					report_mismatch("evicted_tid", evicted_tid, want.ev_tid);
			end
		end
	end

	// Stimulus: reset, directed table, then random phases.
	initial begin
		stim_row_t              row;
		int unsigned            p;
		int unsigned            i;
		int unsigned            n;
		int unsigned            pos;
		logic [TID_W-1:0]       t;
		logic [NAME_LOW_W-1:0]  lo;
		logic [NAME_HIGH_W-1:0] hi;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		tid = '0;
		name_low = '0;
		name_high = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		store_on = 1'b0;
		rr_ptr = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The register comes out of reset cleared, so writes are refused.
		add_item(1'b1, '1, '1, '1, mk_res(STATUS_NOT_READY, 0, 1'b0, 1'b0, '0));
		add_item(1'b1, '0, '0, '0, mk_res(STATUS_NOT_READY, 0, 1'b0, 1'b0, '0));
		add_cfg(1'b1);
		// Id 0 matches the reset owner of slot 0; all-ones evicts id 0 from slot 1.
		add_item(1'b1, '0, '0, '0, mk_res(STATUS_OK, 0, 1'b1, 1'b0, '0));
		add_item(1'b1, '1, '1, '1, mk_res(STATUS_OK, 1, 1'b1, 1'b1, '0));
		add_item(1'b1, '1, '1, '1, mk_res(STATUS_OK, 1, 1'b0, 1'b0, '0));
		// Id 0 lost its map entry to that eviction; then ids sharing entry 0.
		add_item(1'b0, 32'h0000_0000, 64'h0000_0000_0000_4142, '0, '0);
		add_item(1'b0, 32'h0000_8000, 64'h0041_4243_4445_4647, 56'h48_494a_4b4c_4d4e, '0);
		add_item(1'b0, 32'h0000_8000, '1, '0, '0);
		add_item(1'b0, 32'h0000_0000, 64'h7f7f_7f7f_7f7f_7f7f, 56'h7f_7f7f_7f7f_7f7f, '0);
		add_item(1'b0, 32'h8000_7fff, 64'h8080_8080_8080_8080, '1, '0);
		// Names with a zero byte early and in the middle.
		add_item(1'b0, 32'h1234_5678, 64'h00ff_00ff_00ff_0041, 56'hff_ffff_ffff_ffff, '0);
		add_item(1'b0, 32'h1234_5678, 64'hffff_ffff_ffff_ff00, '1, '0);
		add_item(1'b0, 32'ha5a5_a5a5, 64'h5555_5555_5555_5555, 56'haa_aaaa_aaaa_aaaa, '0);
		add_item(1'b0, 32'h5a5a_5a5a, 64'haaaa_aaaa_aaaa_aaaa, 56'h55_5555_5555_5555, '0);
		add_cfg(1'b0);
		add_item(1'b1, 32'h1234_5678, '1, '1,
			mk_res(STATUS_NOT_READY, 0, 1'b0, 1'b0, '0));
		add_cfg(1'b1);
		add_item(1'b0, 32'h1234_5678, 64'h0000_0000_0000_0031, '0, '0);

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.kind == ROW_CFG)
				write_store_ready(row.lo[0]);
			else
				send_name(row.tid, row.lo, row.hi, row.typed, row.res);
		end

		// Random phases; one runs with the store off, two with no idling.
		for (p = 0; p < PHASES; p++) begin
			write_store_ready(p != 3);
			quiet = (p == 1) || (p == 4);
			n = (p == 3) ? 100 : 340;
			for (i = 0; i < n; i++) begin
				if (p == 0 && i == 5)
					hold_req = 1'b1;
				if (p == 2 && i == 170)
					wait_drained();
				t = pick_tid();
				lo = {$urandom, $urandom};
				hi = NAME_HIGH_W'({$urandom, $urandom});
				if ($urandom_range(3) == 0) begin
					pos = $urandom_range(14);
					if (pos < 8)
						lo[pos*8 +: 8] = 8'h00;
					else
						hi[(pos-8)*8 +: 8] = 8'h00;
				end
				send_name(t, lo, hi, 1'b0, '0);
			end
		end

		// Let the last results out, then allow for any stray ones.
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d name updates, checked %0d results: %0d new slots, %0d evictions,",
			names_sent, results_seen, new_slots, evictions);
		$display("%0d refused with the store off; output hold-off and idle gaps on both sides.",
			refused);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: the post-reset clearing pass plus the slowest traffic, with margin.
	initial begin
		#6_000_000;
		$display("timeout with %0d results outstanding", expected_slots.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
